FILE: rtl/dell_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and record types for the debounced edge logger.
// Used by every module under rtl except dell_ram; depends on nothing else.
package dell_pkg;

   // Default sizing handed to the top-level parameters.
   localparam int CHANNELS_DEFAULT  = 8;
   localparam int LOG_DEPTH_DEFAULT = 1024;

   // Field widths of the request and response channels.
   localparam int OPCODE_W    = 2;
   localparam int CHANNEL_W   = 3;
   localparam int DIGIT_W     = 3;
   localparam int LOG_COUNT_W = 11;
   localparam int TICK_W      = 32;
   localparam int HOLD_W      = 16;

   // Lockout time after reset, in ticks.
   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd30;

   // Register port sizing: one 32-bit register at byte address 0.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_HOLD_INDEX = 1'b0;

   // Result queue between the front end and the response port.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request operation codes.
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_EDGE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

   // Outcome of one request as decided by the front end.
   typedef struct packed {
      logic                   edge_accepted;
      logic                   read_valid;
      logic [LOG_COUNT_W-1:0] log_count;
   } front_result_type;

   // One complete response as held in the result queue.
   typedef struct packed {
      logic                   edge_accepted;
      logic                   read_valid;
      logic [DIGIT_W-1:0]     read_digit;
      logic [LOG_COUNT_W-1:0] log_count;
   } rsp_entry_type;

endpackage

FILE: rtl/dell_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module dell_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dell_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, applies the lockout test, keeps tick, deadline and
// log pointers, and drives the log RAM. Depends on dell_pkg.
module dell_front #(
   parameter int CHANNELS  = dell_pkg::CHANNELS_DEFAULT,
   parameter int LOG_DEPTH = dell_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dell_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [dell_pkg::CHANNEL_W-1:0]     req_channel,
   input  logic [dell_pkg::HOLD_W-1:0]        hold_ticks,
   input  logic [dell_pkg::QUEUE_CNT_W-1:0]   q_count,
   output logic                               ram_wr_en,
   output logic [$clog2(LOG_DEPTH)-1:0]       ram_wr_addr,
   output logic [dell_pkg::DIGIT_W-1:0]       ram_wr_data,
   output logic                               ram_rd_en,
   output logic [$clog2(LOG_DEPTH)-1:0]       ram_rd_addr,
   output logic                               s1_valid,
   output dell_pkg::front_result_type         s1_result
);
   import dell_pkg::*;

   localparam int ADDR_W   = $clog2(LOG_DEPTH);
   localparam int CNT_W    = $clog2(LOG_DEPTH + 1);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [TICK_W-1:0]   deadline_ff [CHANNELS];
   logic [TICK_W-1:0]   deadline_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    rpos_ff, rpos_in;
   logic                s1_valid_ff;
   front_result_type    s1_result_ff, s1_result_in;

   logic                accept;
   logic [QUEUE_CNT_W:0] occupancy;
   logic [31:0]         ch_ext;
   logic [CH_IDX_W-1:0] ch_idx;
   logic                ch_ok;
   logic                edge_ok;
   logic                rd_ok;
   logic                log_full;
   logic [31:0]         fill_ext;

   // Take a request only when the queue has room for it beyond the one in flight.
   assign occupancy = {1'b0, q_count} + {{QUEUE_CNT_W{1'b0}}, s1_valid_ff};
   assign req_ready = occupancy < (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // Classify the request: lockout test for edges, end-of-log test for reads.
   assign ch_ext      = {{(32 - CHANNEL_W){1'b0}}, req_channel};
   assign ch_idx      = ch_ext[CH_IDX_W-1:0];
   assign ch_ok       = ch_ext < 32'(CHANNELS);
   assign edge_ok     = (req_opcode == OP_EDGE) && ch_ok && (tick_ff > deadline_ff[ch_idx]);
   assign rd_ok       = (req_opcode == OP_READ) && (rpos_ff < fill_ff);
   assign log_full    = fill_ff == CNT_W'(LOG_DEPTH);
   assign deadline_in = tick_ff + {{(TICK_W - HOLD_W){1'b0}}, hold_ticks};

   // Next values of the tick counter and log pointers.
   always_comb begin
      tick_in = tick_ff;
      fill_in = fill_ff;
      rpos_in = rpos_ff;
      case (req_opcode)
         OP_TICK: begin
            tick_in = tick_ff + TICK_W'(1);
         end
         OP_EDGE: begin
            if (edge_ok) begin
               if (log_full) begin
                  fill_in = CNT_W'(1);
                  rpos_in = '0;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
         OP_READ: begin
            if (rd_ok) begin
               rpos_in = rpos_ff + CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            fill_in = '0;
            rpos_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Log RAM accesses: append at the fill point, read at the read position.
   assign ram_wr_en   = accept && edge_ok;
   assign ram_wr_addr = log_full ? '0 : fill_ff[ADDR_W-1:0];
   assign ram_wr_data = req_channel;
   assign ram_rd_en   = accept && rd_ok;
   assign ram_rd_addr = rpos_ff[ADDR_W-1:0];

   // Outcome of the request, registered to meet the RAM read data.
   assign fill_ext                   = 32'(fill_in);
   assign s1_result_in.edge_accepted = edge_ok;
   assign s1_result_in.read_valid    = rd_ok;
   assign s1_result_in.log_count     = fill_ext[LOG_COUNT_W-1:0];

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         fill_ff     <= '0;
         rpos_ff     <= '0;
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            deadline_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            tick_ff <= tick_in;
            fill_ff <= fill_in;
            rpos_ff <= rpos_in;
            if (edge_ok) begin
               deadline_ff[ch_idx] <= deadline_in;
            end
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= s1_result_in;
      end
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_result = s1_result_ff;

endmodule

FILE: rtl/dell_queue.sv
`timescale 1ns / 1ps
// Back end: a short result queue whose head drives the response channel.
// Depends on dell_pkg.
module dell_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push_valid,
   input  dell_pkg::rsp_entry_type            push_data,
   output logic [dell_pkg::QUEUE_CNT_W-1:0]   q_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_edge_accepted,
   output logic                               rsp_read_valid,
   output logic [dell_pkg::DIGIT_W-1:0]       rsp_read_digit,
   output logic [dell_pkg::LOG_COUNT_W-1:0]   rsp_log_count
);
   import dell_pkg::*;

   rsp_entry_type          entry_ff [QUEUE_DEPTH];
   rsp_entry_type          head;
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   // Pointer and count update; the front end never pushes into a full queue.
   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_in = push_valid ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The head entry is the response on offer.
   assign head              = entry_ff[rd_ptr_ff];
   assign q_count           = count_ff;
   assign rsp_valid         = count_ff != '0;
   assign rsp_edge_accepted = head.edge_accepted;
   assign rsp_read_valid    = head.read_valid;
   assign rsp_read_digit    = head.read_digit;
   assign rsp_log_count     = head.log_count;

endmodule

FILE: rtl/debounced_edge_event_logger.sv
`timescale 1ns / 1ps
// Debounced edge event logger, top level.
// Depends on dell_pkg, dell_front, dell_ram and dell_queue.
//
// Each request carries an opcode: tick advances the tick counter, edge offers
// an edge on a channel, read returns the next logged channel number,
// clear empties the log. An edge is taken only when the tick count is strictly
// past that channel's deadline; the deadline then becomes tick count plus
// hold_ticks and the channel is appended to the log (a full log is emptied first).
// Every request yields exactly one response, in request order.
//
// Accepted requests pass the front-end result register, then the result queue.
// The front end accepts one request every cycle while req_ready is high; its
// single log RAM access per request sets that rate. A four-entry result queue
// decouples the sides: while the receiver stalls, requests keep being taken
// until the queue is full, then req_ready drops.
//
// Synchronous reset clears tick count, deadlines, log pointers and the queue,
// and sets hold_ticks to 30. The log RAM needs no clearing pass.
// hold_ticks sits at byte address 0 of the register port.
module debounced_edge_event_logger #(
   parameter int CHANNELS  = dell_pkg::CHANNELS_DEFAULT,
   parameter int LOG_DEPTH = dell_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dell_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [dell_pkg::CHANNEL_W-1:0]     req_channel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_edge_accepted,
   output logic                               rsp_read_valid,
   output logic [dell_pkg::DIGIT_W-1:0]       rsp_read_digit,
   output logic [dell_pkg::LOG_COUNT_W-1:0]   rsp_log_count,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dell_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [dell_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [dell_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import dell_pkg::*;

   localparam int ADDR_W = $clog2(LOG_DEPTH);

   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic                   hold_sel;
   logic                   csr_write;
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [DIGIT_W-1:0]     ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [DIGIT_W-1:0]     ram_rd_data;
   logic                   s1_valid;
   front_result_type       s1_result;
   rsp_entry_type          push_data;
   logic [QUEUE_CNT_W-1:0] q_count;

   // Register port: hold_ticks is the only register.
   assign pready    = 1'b1;
   assign hold_sel  = paddr[2] == CSR_HOLD_INDEX;
   assign csr_write = psel && penable && pwrite && pready && hold_sel;
   assign hold_in   = csr_write ? pwdata[HOLD_W-1:0] : hold_ff;
   assign prdata    = hold_sel ? {{(CSR_DATA_W - HOLD_W){1'b0}}, hold_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_RESET;
      end else begin
         hold_ff <= hold_in;
      end
   end

   // Front end: classification and state update.
   dell_front #(
      .CHANNELS  (CHANNELS),
      .LOG_DEPTH (LOG_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_channel (req_channel),
      .hold_ticks  (hold_ff),
      .q_count     (q_count),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .s1_valid    (s1_valid),
      .s1_result   (s1_result)
   );

   // Log store.
   dell_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Merge the read data with the front-end outcome.
   assign push_data.edge_accepted = s1_result.edge_accepted;
   assign push_data.read_valid    = s1_result.read_valid;
   assign push_data.read_digit    = s1_result.read_valid ? ram_rd_data : '0;
   assign push_data.log_count     = s1_result.log_count;

   // Back end: result queue and response channel.
   dell_queue u_queue (
      .clock             (clock),
      .reset             (reset),
      .push_valid        (s1_valid),
      .push_data         (push_data),
      .q_count           (q_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_edge_accepted (rsp_edge_accepted),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_digit    (rsp_read_digit),
      .rsp_log_count     (rsp_log_count)
   );

   // A result never arrives at a full queue.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid |-> q_count != QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result pushed into a full queue");

   // Every accepted request reaches the merge stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid)
      else $error("accepted request lost before the queue");

   // A returned digit implies a nonempty log.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_valid) |-> rsp_log_count != '0)
      else $error("digit returned from an empty log");

   // An edge and a digit never share one response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_edge_accepted && rsp_read_valid))
      else $error("response reports both an edge and a read");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for debounced_edge_event_logger: drives ticks, edges, reads and clears,
// predicts every response in a scoreboard class and checks it field by field.
// Depends on dell_pkg and the debounced_edge_event_logger RTL.
module tb;
   import dell_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam logic [CSR_ADDR_W-1:0] HOLD_ADDR = CSR_ADDR_W'(4 * CSR_HOLD_INDEX);

   // Scoreboard: own copy of lockout deadlines and the log, plus the responses still due.
   class edge_log_tracker;
      logic [HOLD_W-1:0]    hold;
      logic [TICK_W-1:0]    ticks;
      logic [TICK_W-1:0]    deadline [CHANNELS_DEFAULT];
      logic [DIGIT_W-1:0]   digits [LOG_DEPTH_DEFAULT];
      int unsigned          fill;
      int unsigned          rd_pos;
      rsp_entry_type        due [$];
      int unsigned          failures;
      int unsigned          requests;
      int unsigned          responses;
      int unsigned          edges_logged;
      int unsigned          digits_read;
      int unsigned          wraps;

      function new();
         hold = HOLD_RESET;
         ticks = '0;
         foreach (deadline[i]) deadline[i] = '0;
         fill = 0;
         rd_pos = 0;
         failures = 0;
         requests = 0;
         responses = 0;
         edges_logged = 0;
         digits_read = 0;
         wraps = 0;
      endfunction

      // Work out the response of one accepted request and queue it.
      function void apply_request(logic [OPCODE_W-1:0] op, logic [CHANNEL_W-1:0] ch);
         rsp_entry_type r;
         r = '0;
         case (op)
            OP_TICK: ticks = ticks + 1;
            OP_EDGE: begin
               if (ch < CHANNELS_DEFAULT && ticks > deadline[ch]) begin
                  deadline[ch] = ticks + TICK_W'(hold);
                  // A full log is emptied before the new digit goes in.
                  if (fill >= LOG_DEPTH_DEFAULT) begin
                     fill = 0;
                     rd_pos = 0;
                     wraps++;
                  end
                  digits[fill] = ch;
                  fill++;
                  r.edge_accepted = 1'b1;
                  edges_logged++;
               end
            end
            OP_READ: begin
               if (rd_pos < fill) begin
                  r.read_valid = 1'b1;
                  r.read_digit = digits[rd_pos];
                  rd_pos++;
                  digits_read++;
               end
            end
            default: begin
               fill = 0;
               rd_pos = 0;
            end
         endcase
         r.log_count = LOG_COUNT_W'(fill);
         due.push_back(r);
         requests++;
      endfunction

      // Compare one response with the oldest one still due.
      function void match_response(rsp_entry_type got);
         rsp_entry_type want;
         if (due.size() == 0) begin
            $error("response with no request outstanding: acc %0d valid %0d digit %0d count %0d",
                   got.edge_accepted, got.read_valid, got.read_digit, got.log_count);
            failures++;
            return;
         end
         want = due.pop_front();
         responses++;
         if (got.edge_accepted !== want.edge_accepted) begin
            $error("edge_accepted: expected %0d, got %0d", want.edge_accepted, got.edge_accepted);
            failures++;
         end
         if (got.read_valid !== want.read_valid) begin
            $error("read_valid: expected %0d, got %0d", want.read_valid, got.read_valid);
            failures++;
         end
         if (got.read_digit !== want.read_digit) begin
            $error("read_digit: expected %0d, got %0d", want.read_digit, got.read_digit);
            failures++;
         end
         if (got.log_count !== want.log_count) begin
            $error("log_count: expected %0d, got %0d", want.log_count, got.log_count);
            failures++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OPCODE_W-1:0]    req_opcode = OP_TICK;
   logic [CHANNEL_W-1:0]   req_channel = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_edge_accepted;
   logic                   rsp_read_valid;
   logic [DIGIT_W-1:0]     rsp_read_digit;
   logic [LOG_COUNT_W-1:0] rsp_log_count;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr = '0;
   logic [CSR_DATA_W-1:0]  pwdata = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;
   int                     quiet_cycles = 0;
   edge_log_tracker        book = new();

   debounced_edge_event_logger dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_channel       (req_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_edge_accepted (rsp_edge_accepted),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_digit    (rsp_read_digit),
      .rsp_log_count     (rsp_log_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response side: check each accepted response, then decide whether to stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            book.match_response('{edge_accepted: rsp_edge_accepted, read_valid: rsp_read_valid,
                                  read_digit: rsp_read_digit, log_count: rsp_log_count});
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Idling modes: none, sender idle, receiver stalling, both.
   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
         default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
   endtask

   // Offer one request, holding it until accepted, and note it with the scoreboard.
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [CHANNEL_W-1:0] ch);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_channel <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.apply_request(op, ch);
   endtask

   // Drop valid and wait until every response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (book.due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write hold_ticks while idle, then read it back.
   task automatic write_hold(input logic [CSR_DATA_W-1:0] value);
      settle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= HOLD_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DATA_W'(value[HOLD_W-1:0])) begin
         $error("hold_ticks readback: expected %0d, got %0d", value[HOLD_W-1:0], prdata);
         book.failures++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      book.hold = value[HOLD_W-1:0];
   endtask

   // Well-formed rounds: a tick, then an edge on every channel in shuffled order.
   // With a zero hold time the first edge per channel in each round passes, so the log fills and wraps.
   task automatic fill_rounds(input int rounds);
      logic [CHANNEL_W-1:0] order [CHANNELS_DEFAULT];
      logic [CHANNEL_W-1:0] swap;
      int                   j;
      for (int r = 0; r < rounds; r++) begin
         for (int i = 0; i < CHANNELS_DEFAULT; i++) order[i] = CHANNEL_W'(i);
         for (int i = CHANNELS_DEFAULT - 1; i > 0; i--) begin
            j = $urandom_range(i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
         end
         send_request(OP_TICK, CHANNEL_W'($urandom_range(7)));
         for (int i = 0; i < CHANNELS_DEFAULT; i++) begin
            send_request(OP_EDGE, order[i]);
            if ($urandom_range(99) < 4) send_request(OP_READ, CHANNEL_W'($urandom_range(7)));
         end
         // An occasional repeat edge within the same tick must be locked out.
         if ($urandom_range(99) < 15) send_request(OP_EDGE, CHANNEL_W'($urandom_range(7)));
      end
   endtask

   // Random mix of operations with the given weights.
   task automatic random_requests(input int count, input int tick_w, input int edge_w,
                                  input int read_w);
      int                  pick;
      logic [OPCODE_W-1:0] op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < tick_w) op = OP_TICK;
         else if (pick < tick_w + edge_w) op = OP_EDGE;
         else if (pick < tick_w + edge_w + read_w) op = OP_READ;
         else op = OP_CLEAR;
         send_request(op, CHANNEL_W'($urandom_range(7)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // Directed part at the reset hold time of 30 ticks.
      send_request(OP_READ, 3'd0);    // read of an empty log
      send_request(OP_EDGE, 3'd0);    // tick count not yet past the zero deadline
      send_request(OP_TICK, 3'd7);
      send_request(OP_EDGE, 3'd0);
      send_request(OP_EDGE, 3'd0);    // locked out
      send_request(OP_EDGE, 3'd7);
      send_request(OP_READ, 3'd7);
      send_request(OP_READ, 3'd0);
      send_request(OP_READ, 3'd0);    // end of log
      send_request(OP_EDGE, 3'd7);    // locked out
      send_request(OP_CLEAR, 3'd0);
      send_request(OP_READ, 3'd0);    // nothing left after the clear
      send_request(OP_CLEAR, 3'd7);
      send_request(OP_EDGE, 3'd7);    // still locked out after the clear
      send_request(OP_READ, 3'd5);
      send_request(OP_CLEAR, 3'd2);

      // Zero hold time: fill the log past full so that it wraps.
      write_hold({16'($urandom_range(65535)), 16'h0000});
      for (int m = 0; m < 4; m++) begin
         set_idling(m);
         fill_rounds(35);
      end

      // Longest hold time: edges after the first on a channel stay locked out.
      write_hold({16'($urandom_range(65535)), 16'hFFFF});
      for (int m = 0; m < 4; m++) begin
         set_idling(m);
         random_requests(30, 40, 35, 20);
      end

      // Short hold times so that deadlines expire often.
      write_hold({16'($urandom_range(65535)), 16'($urandom_range(6, 1))});
      for (int m = 0; m < 4; m++) begin
         set_idling(m);
         random_requests(50, 35, 40, 20);
      end

      settle();
      repeat (8) @(posedge clock);
      $display("tb: %0d requests, %0d responses checked, %0d edges logged, %0d log wraps",
               book.requests, book.responses, book.edges_logged, book.wraps);
      $display("tb: %0d digits read back under four idling modes and three hold times",
               book.digits_read);
      if (book.failures == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dell_pkg.sv
rtl/dell_ram.sv
rtl/dell_front.sv
rtl/dell_queue.sv
rtl/debounced_edge_event_logger.sv
tb/sv/tb.sv
